@@ rtl/max_step_to_bounds_core_macros.svh @@
// assertion macros for the step-limit core checker
// no dependencies; included by the checker file
`ifndef MAX_STEP_TO_BOUNDS_CORE_MACROS_SVH
`define MAX_STEP_TO_BOUNDS_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MSTB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mstb assertion failed");

// next-cycle implication, disabled while reset is asserted
`define MSTB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mstb assertion failed");

// next-cycle implication that also holds through reset
`define MSTB_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mstb assertion failed");

`endif

@@ rtl/mstb_pkg.sv @@
// shared widths and divider request/response types for the step-limit core
// no dependencies
`default_nettype none

package mstb_pkg;

    localparam int Q_W     = 32;             // signed q16.16 operand width
    localparam int LIM_W   = 31;             // unsigned step limit width
    localparam int FRAC_W  = 16;             // fractional bits
    localparam int DIFF_W  = Q_W + 1;        // bound minus point, no overflow
    localparam int DVD_W   = DIFF_W + FRAC_W; // scaled dividend width
    localparam int CNT_W   = $clog2(DVD_W);  // divider step counter width
    localparam int MAX_DIM = 4096;           // longest vector
    localparam int POS_W   = $clog2(MAX_DIM);

    localparam logic [LIM_W-1:0] LIM_MAX = {LIM_W{1'b1}};

    // divider launch
    typedef struct packed {
        logic              start;
        logic [DIFF_W-1:0] dividend;  // magnitude, before scaling
        logic [Q_W-1:0]    divisor;   // magnitude, nonzero
    } t_div_req;

    // divider completion
    typedef struct packed {
        logic             done;
        logic [LIM_W-1:0] quot;     // saturated quotient
    } t_div_rsp;

endpackage

`default_nettype wire

@@ rtl/mstb_if.sv @@
// valid/ready channel interfaces for coordinate items and step-limit results
// depends on mstb_pkg
`default_nettype none

interface mstb_item_if
    import mstb_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    first;
    logic [LIM_W-1:0]        initial_limit;
    logic [POS_W-1:0]        position;
    logic signed [Q_W-1:0]   point_value;
    logic signed [Q_W-1:0]   direction;
    logic signed [Q_W-1:0]   lower_bound;
    logic signed [Q_W-1:0]   upper_bound;
    logic                    last;

    modport source (
        output valid, first, initial_limit, position, point_value, direction,
               lower_bound, upper_bound, last,
        input  ready
    );
    modport sink (
        input  valid, first, initial_limit, position, point_value, direction,
               lower_bound, upper_bound, last,
        output ready
    );
endinterface

interface mstb_result_if
    import mstb_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [LIM_W-1:0] step_limit;

    modport source (output valid, step_limit, input ready);
    modport sink (input valid, step_limit, output ready);
endinterface

`default_nettype wire

@@ rtl/mstb_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle, saturating output
// depends on mstb_pkg
`default_nettype none

module mstb_div
    import mstb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVD_W-1:0]  r_dvd;
    logic [Q_W-1:0]    r_dvs;
    logic [Q_W-1:0]    r_rem;
    logic [LIM_W-1:0]  r_quo;
    logic              r_sat;

    logic [DIFF_W-1:0] w_trial;
    logic [DIFF_W-1:0] w_sub;
    logic              w_ge;

    // trial subtract of the divisor from the shifted partial remainder
    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_sub   = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits at or above the limit width only set saturation
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= {i_req.dividend, {FRAC_W{1'b0}}};
            r_dvs <= i_req.divisor;
            r_rem <= '0;
            r_quo <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= w_ge ? w_sub[Q_W-1:0] : w_trial[Q_W-1:0];
            r_quo <= {r_quo[LIM_W-2:0], w_ge};
            r_sat <= r_sat | (w_ge & (r_cnt >= CNT_W'(LIM_W)));
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_sat ? LIM_MAX : r_quo;

endmodule

`default_nettype wire

@@ rtl/max_step_to_bounds_core.sv @@
// ratio test core: per bound a diff state and a sign-test state, plus a wait on the
// divider when it divides (49 serial divider steps, then the quotient is taken); the
// idle state accepts a coordinate, and only once the previous one is finished; a last
// coordinate also passes the emit state, which waits while an earlier result is held
// reset: synchronous active low, clears the running limit to zero and drops valids
// depends on mstb_pkg, mstb_if, mstb_div
`default_nettype none

module max_step_to_bounds_core
    import mstb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    mstb_item_if.sink     i_item,
    mstb_result_if.source o_result
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIFF = 5'b00010,
        S_TEST = 5'b00100,
        S_WAIT = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [LIM_W-1:0]  r_limit, n_limit;
    logic              r_sel, n_sel;
    logic              r_out_valid, n_out_valid;
    logic [LIM_W-1:0]  r_out_limit;
    logic [Q_W-1:0]    r_pt, r_dir, r_lo, r_hi;
    logic              r_last;
    logic [DIFF_W-1:0] r_diff;

    logic              w_accept;
    logic              w_qual;
    logic              w_load_out;
    logic [Q_W-1:0]    w_bound;
    t_state            w_after;
    t_div_req          w_req;
    t_div_rsp          w_rsp;

    assign w_accept = i_item.valid & i_item.ready;

    // bound under test: upper first, then lower
    assign w_bound = r_sel ? r_lo : r_hi;

    // diff and direction share a strict sign
    assign w_qual = (!r_dir[Q_W-1] && (r_dir != '0) && !r_diff[DIFF_W-1] && (r_diff != '0))
                  || (r_dir[Q_W-1] && r_diff[DIFF_W-1]);

    // where to go once the current bound is finished
    assign w_after = !r_sel ? S_DIFF : (r_last ? S_EMIT : S_IDLE);

    assign w_load_out = (r_state == S_EMIT) && (!r_out_valid || o_result.ready);

    // divider launch with operand magnitudes
    assign w_req.start    = (r_state == S_TEST) && w_qual;
    assign w_req.dividend = r_diff[DIFF_W-1] ? (~r_diff + 1'b1) : r_diff;
    assign w_req.divisor  = r_dir[Q_W-1] ? (~r_dir + 1'b1) : r_dir;

    mstb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_limit     = r_limit;
        n_sel       = r_sel;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_sel   = 1'b0;
                    n_state = S_DIFF;
                    if (i_item.first) begin
                        n_limit = i_item.initial_limit;
                    end
                end
            end
            S_DIFF: begin
                n_state = S_TEST;
            end
            S_TEST: begin
                if (w_qual) begin
                    n_state = S_WAIT;
                end else begin
                    n_sel   = 1'b1;
                    n_state = w_after;
                end
            end
            S_WAIT: begin
                if (w_rsp.done) begin
                    if (w_rsp.quot < r_limit) begin
                        n_limit = w_rsp.quot;
                    end
                    n_sel   = 1'b1;
                    n_state = w_after;
                end
            end
            S_EMIT: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_limit     <= n_limit;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pt   <= i_item.point_value;
            r_dir  <= i_item.direction;
            r_lo   <= i_item.lower_bound;
            r_hi   <= i_item.upper_bound;
            r_last <= i_item.last;
        end
        if (r_state == S_DIFF) begin
            r_diff <= {w_bound[Q_W-1], w_bound} - {r_pt[Q_W-1], r_pt};
        end
        if (w_load_out) begin
            r_out_limit <= r_limit;
        end
    end

    assign i_item.ready        = (r_state == S_IDLE);
    assign o_result.valid      = r_out_valid;
    assign o_result.step_limit = r_out_limit;

endmodule

`default_nettype wire

@@ rtl/mstb_chk.sv @@
// port-level checker for the step-limit core, bound to the top level
// depends on mstb_pkg and max_step_to_bounds_core_macros.svh
`default_nettype none
`include "max_step_to_bounds_core_macros.svh"

module mstb_chk
    import mstb_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [LIM_W-1:0] i_step_limit
);

    // a held result keeps valid high
    `MSTB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // a stalled result keeps its value
    `MSTB_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_step_limit))

    // one coordinate in flight: busy right after an accepted transaction
    `MSTB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // no result directly out of reset
    `MSTB_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind max_step_to_bounds_core mstb_chk u_mstb_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_step_limit (o_result.step_limit)
);

`default_nettype wire
